// File: src/jsu_pkg.sv
package jsu_pkg;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_RED_START,
    DP_MOD_STEP,
    DP_TAKE,
    DP_HALVE,
    DP_SWAP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } jsu_cmd_t;

  typedef struct packed {
    logic m_lt2;
    logic m_is2;
    logic m_even;
    logic a_lsb;
    logic a_zero;
    logic mod_last;
    logic n_is1;
    logic t_neg;
  } jsu_stat_t;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_MOD     = 2'd1;
  localparam logic [1:0] ST_NOT_COPRIME = 2'd2;
  localparam logic [1:0] ST_EVEN_MOD    = 2'd3;

  localparam logic [1:0] SYM_ZERO = 2'b00;
  localparam logic [1:0] SYM_POS  = 2'b01;
  localparam logic [1:0] SYM_NEG  = 2'b11;

endpackage

// File: src/jacobi_symbol_unit.sv
// Channel   Ports                               Handshake
// input     in_residue, in_modulus              beat taken when start high and busy low
// result    out_symbol, out_status              one-cycle beat marked by out_valid
//
// Each item is loaded and checked; a modulus that is rejected, even or equal to two ends
// there. Otherwise the unit runs reductions, halvings and swaps until the residue is zero.
// The remainder comes from a bit-serial unit, one quotient bit per cycle.
// Reset clears only the controller state and valid flag; no clearing pass is needed.
// The result beat cannot be stalled, and busy stays high until it is issued.
module jacobi_symbol_unit
  import jsu_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [WORD_BITS-1:0] in_residue,
  input  logic signed [WORD_BITS-1:0] in_modulus,
  output logic                        out_valid,
  output logic signed [1:0]           out_symbol,
  output logic [1:0]                  out_status
);

  jsu_cmd_t   cmd;
  jsu_stat_t  stat;
  logic [1:0] sym;

  jsu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .stat       (stat),
    .cmd        (cmd),
    .out_valid  (out_valid),
    .out_symbol (sym),
    .out_status (out_status)
  );

  jsu_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .in_residue (in_residue),
    .in_modulus (in_modulus),
    .stat       (stat)
  );

  assign out_symbol = $signed(sym);

endmodule

// File: src/jsu_datapath.sv
module jsu_datapath
  import jsu_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  jsu_cmd_t                    cmd,
  input  logic signed [WORD_BITS-1:0] in_residue,
  input  logic signed [WORD_BITS-1:0] in_modulus,
  output jsu_stat_t                   stat
);

  localparam int CNT_W = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] a_r;
  logic [WORD_BITS-1:0] n_r;
  logic [WORD_BITS-1:0] div_r;
  logic [WORD_BITS-1:0] rem_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 neg_r;
  logic                 t_r;

  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   diff;
  logic [WORD_BITS-1:0] rem_nxt;
  logic [WORD_BITS-1:0] a_abs;
  logic [2:0]           n_mod8;

  assign trial   = {rem_r, div_r[WORD_BITS-1]};
  assign diff    = trial - {1'b0, n_r};
  assign rem_nxt = diff[WORD_BITS] ? trial[WORD_BITS-1:0] : diff[WORD_BITS-1:0];
  assign a_abs   = a_r[WORD_BITS-1] ? ('0 - a_r) : a_r;
  assign n_mod8  = n_r[2:0];

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        a_r <= in_residue;
        n_r <= in_modulus;
        t_r <= 1'b0;
      end
      DP_RED_START: begin
        div_r <= a_abs;
        neg_r <= a_r[WORD_BITS-1];
        rem_r <= '0;
        cnt_r <= CNT_W'(WORD_BITS - 1);
      end
      DP_MOD_STEP: begin
        rem_r <= rem_nxt;
        div_r <= {div_r[WORD_BITS-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
      end
      DP_TAKE: begin
        a_r <= (neg_r && rem_r != '0) ? (n_r - rem_r) : rem_r;
      end
      DP_HALVE: begin
        a_r <= {1'b0, a_r[WORD_BITS-1:1]};
        if (n_mod8 == 3'd3 || n_mod8 == 3'd5) begin
          t_r <= ~t_r;
        end
      end
      DP_SWAP: begin
        a_r   <= n_r;
        n_r   <= a_r;
        div_r <= n_r;
        rem_r <= '0;
        neg_r <= 1'b0;
        cnt_r <= CNT_W'(WORD_BITS - 1);
        if (a_r[1:0] == 2'b11 && n_r[1:0] == 2'b11) begin
          t_r <= ~t_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.m_lt2    = n_r[WORD_BITS-1] || (n_r[WORD_BITS-1:1] == '0);
    stat.m_is2    = (n_r == WORD_BITS'(2));
    stat.m_even   = ~n_r[0];
    stat.a_lsb    = a_r[0];
    stat.a_zero   = (a_r == '0);
    stat.mod_last = (cnt_r == '0);
    stat.n_is1    = (n_r == WORD_BITS'(1));
    stat.t_neg    = t_r;
  end

endmodule

// File: src/jsu_ctrl.sv
module jsu_ctrl
  import jsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  jsu_stat_t   stat,
  output jsu_cmd_t    cmd,
  output logic        out_valid,
  output logic [1:0]  out_symbol,
  output logic [1:0]  out_status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RED,
    S_TAKE,
    S_LOOP
  } state_t;

  state_t     state_r, state_nxt;
  logic       valid_r, valid_nxt;
  logic [1:0] sym_r, sym_nxt;
  logic [1:0] st_r, st_nxt;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    sym_nxt   = sym_r;
    st_nxt    = st_r;
    cmd.op    = DP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat.m_lt2) begin
          valid_nxt = 1'b1;
          sym_nxt   = SYM_ZERO;
          st_nxt    = ST_BAD_MOD;
          state_nxt = S_IDLE;
        end else if (stat.m_is2) begin
          valid_nxt = 1'b1;
          sym_nxt   = stat.a_lsb ? SYM_POS : SYM_ZERO;
          st_nxt    = ST_OK;
          state_nxt = S_IDLE;
        end else if (stat.m_even) begin
          valid_nxt = 1'b1;
          sym_nxt   = SYM_ZERO;
          st_nxt    = ST_EVEN_MOD;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = DP_RED_START;
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        cmd.op = DP_MOD_STEP;
        if (stat.mod_last) begin
          state_nxt = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd.op    = DP_TAKE;
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        priority if (stat.a_zero) begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
          if (stat.n_is1) begin
            sym_nxt = stat.t_neg ? SYM_NEG : SYM_POS;
            st_nxt  = ST_OK;
          end else begin
            sym_nxt = SYM_ZERO;
            st_nxt  = ST_NOT_COPRIME;
          end
        end else if (!stat.a_lsb) begin
          cmd.op = DP_HALVE;
        end else begin
          cmd.op    = DP_SWAP;
          state_nxt = S_RED;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    sym_r <= sym_nxt;
    st_r  <= st_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = valid_r;
  assign out_symbol = sym_r;
  assign out_status = st_r;

endmodule

// File: verif/jacobi_symbol_unit_tb.sv
`timescale 1ns / 100ps

module jacobi_symbol_unit_tb;
  import jsu_pkg::*;

  localparam int W = 32;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 680;
  localparam logic signed [W-1:0] W_MIN = 32'sh8000_0000;
  localparam logic signed [W-1:0] W_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [1:0] symbol;
    logic [1:0] status;
  } jacobi_t;

  typedef struct packed {
    logic signed [W-1:0] residue;
    logic signed [W-1:0] modulus;
    jacobi_t             want;
  } pending_t;

  typedef struct packed {
    logic signed [W-1:0] residue;
    logic signed [W-1:0] modulus;
    logic                typed;
    jacobi_t             want;
  } stim_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic signed [W-1:0] in_residue;
  logic signed [W-1:0] in_modulus;
  logic                out_valid;
  logic signed [1:0]   out_symbol;
  logic [1:0]          out_status;

  pending_t pending_symbols[$];
  int       mismatches = 0;
  int       idle_cycles;
  int       burst_left;

  jacobi_symbol_unit #(.WORD_BITS(W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_residue (in_residue),
    .in_modulus (in_modulus),
    .out_valid  (out_valid),
    .out_symbol (out_symbol),
    .out_status (out_status)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic jacobi_t jacobi_of(logic signed [W-1:0] a_in, logic signed [W-1:0] m_in);
    longint          sa;
    longint unsigned n, r, x, y, tmp;
    bit              neg;
    jacobi_t         res;
    res = '{SYM_ZERO, ST_OK};
    sa = a_in;
    if (m_in < 2) begin
      res.status = ST_BAD_MOD;
      return res;
    end
    n = longint'(m_in);
    if (sa < 0) begin
      tmp = longint'(-sa) % n;
      r = (tmp == 0) ? 0 : n - tmp;
    end else begin
      r = longint'(sa) % n;
    end
    if (n == 2) begin
      res.symbol = (r != 0) ? SYM_POS : SYM_ZERO;
      return res;
    end
    if (!n[0]) begin
      res.status = ST_EVEN_MOD;
      return res;
    end
    x = r;
    y = n;
    while (x != 0) begin
      tmp = y % x;
      y = x;
      x = tmp;
    end
    if (y != 1) begin
      res.status = ST_NOT_COPRIME;
      return res;
    end
    x = r;
    y = n;
    neg = 1'b0;
    while (x != 0) begin
      while (!x[0]) begin
        x = x >> 1;
        if (y[2:0] == 3'd3 || y[2:0] == 3'd5) neg = !neg;
      end
      tmp = x;
      x = y;
      y = tmp;
      if (x[1:0] == 2'd3 && y[1:0] == 2'd3) neg = !neg;
      x = x % y;
    end
    res.symbol = neg ? SYM_NEG : SYM_POS;
    return res;
  endfunction

  task automatic send_beat(logic signed [W-1:0] residue, logic signed [W-1:0] modulus,
                           logic typed, jacobi_t typed_want);
    pending_t p;
    start      <= 1'b1;
    in_residue <= residue;
    in_modulus <= modulus;
    @(posedge clk);
    while (busy) @(posedge clk);
    p.residue = residue;
    p.modulus = modulus;
    p.want    = typed ? typed_want : jacobi_of(residue, modulus);
    pending_symbols.push_back(p);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 16);
    case ($urandom_range(0, 7))
      0, 1:    gap = 0;
      2:       gap = $urandom_range(200, 1500);
      default: gap = $urandom_range(1, 40);
    endcase
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_symbols.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    pending_t p;
    if (rst_n && out_valid) begin
      if (pending_symbols.size() == 0) begin
        mismatches++;
        $display("%0t unexpected beat: expected none actual symbol %0d status %0d",
                 $time, out_symbol, out_status);
      end else begin
        p = pending_symbols.pop_front();
        if (out_symbol !== p.want.symbol) begin
          mismatches++;
          $display("%0t symbol (%0d / %0d): expected %0d actual %0d", $time,
                   p.residue, p.modulus, $signed(p.want.symbol), out_symbol);
        end
        if (out_status !== p.want.status) begin
          mismatches++;
          $display("%0t status (%0d / %0d): expected %0d actual %0d", $time,
                   p.residue, p.modulus, p.want.status, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_t               directed_rows[$];
    stim_t               row;
    logic signed [W-1:0] res_v, mod_v;
    logic [31:0]         u;
    longint              p, q;
    burst_left  = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_residue  = '0;
    in_modulus  = '0;

    directed_rows.push_back('{32'sd5, 32'sd0, 1'b1, '{SYM_ZERO, ST_BAD_MOD}});
    directed_rows.push_back('{32'sd5, 32'sd1, 1'b1, '{SYM_ZERO, ST_BAD_MOD}});
    directed_rows.push_back('{32'sd7, -32'sd5, 1'b1, '{SYM_ZERO, ST_BAD_MOD}});
    directed_rows.push_back('{W_MAX, W_MIN, 1'b1, '{SYM_ZERO, ST_BAD_MOD}});
    directed_rows.push_back('{32'sd3, 32'sd2, 1'b1, '{SYM_POS, ST_OK}});
    directed_rows.push_back('{-32'sd1, 32'sd2, 1'b1, '{SYM_POS, ST_OK}});
    directed_rows.push_back('{W_MIN, 32'sd2, 1'b1, '{SYM_ZERO, ST_OK}});
    directed_rows.push_back('{32'sd4, 32'sd2, 1'b1, '{SYM_ZERO, ST_OK}});
    directed_rows.push_back('{32'sd1, 32'sd4, 1'b1, '{SYM_ZERO, ST_EVEN_MOD}});
    directed_rows.push_back('{32'sd7, W_MAX - 1, 1'b1, '{SYM_ZERO, ST_EVEN_MOD}});
    directed_rows.push_back('{32'sd0, 32'sd9, 1'b1, '{SYM_ZERO, ST_NOT_COPRIME}});
    directed_rows.push_back('{32'sd15, 32'sd9, 1'b1, '{SYM_ZERO, ST_NOT_COPRIME}});
    directed_rows.push_back('{W_MAX, W_MAX, 1'b1, '{SYM_ZERO, ST_NOT_COPRIME}});
    directed_rows.push_back('{-32'sd9, 32'sd9, 1'b1, '{SYM_ZERO, ST_NOT_COPRIME}});
    directed_rows.push_back('{32'sd1, 32'sd3, 1'b1, '{SYM_POS, ST_OK}});
    directed_rows.push_back('{32'sd2, 32'sd3, 1'b0, '{SYM_ZERO, ST_OK}});
    directed_rows.push_back('{32'sd2, 32'sd7, 1'b0, '{SYM_ZERO, ST_OK}});
    directed_rows.push_back('{-32'sd1, 32'sd3, 1'b0, '{SYM_ZERO, ST_OK}});
    directed_rows.push_back('{-32'sd1, 32'sd5, 1'b0, '{SYM_ZERO, ST_OK}});
    directed_rows.push_back('{W_MIN, W_MAX, 1'b0, '{SYM_ZERO, ST_OK}});
    directed_rows.push_back('{W_MIN, 32'sd3, 1'b0, '{SYM_ZERO, ST_OK}});
    directed_rows.push_back('{-32'sd2, W_MAX, 1'b0, '{SYM_ZERO, ST_OK}});
    directed_rows.push_back('{W_MAX - 1, W_MAX - 2, 1'b0, '{SYM_ZERO, ST_OK}});
    directed_rows.push_back('{32'sd1001, 32'sd9907, 1'b0, '{SYM_ZERO, ST_OK}});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_beat(row.residue, row.modulus, row.typed, row.want);
      pace_sender();
    end

    drain_results();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      u = $urandom;
      res_v = $urandom;
      case ($urandom_range(0, 19))
        0, 1: begin
          mod_v = $urandom_range(0, 3) == 0 ? $signed($urandom_range(0, 1))
                                            : $signed(u | 32'h8000_0000);
        end
        2: begin
          mod_v = 32'sd2;
        end
        3: begin
          mod_v = {1'b0, u[30:1], 1'b0};
          if (mod_v <= 2) mod_v = 32'sd4;
        end
        4, 5: begin
          p = 2 * $urandom_range(1, 500) + 1;
          q = 2 * $urandom_range(0, 1000000) + 1;
          mod_v = W'(p * q);
          res_v = W'(p * (longint'($urandom_range(0, 2000000)) - 1000000));
        end
        6, 7: begin
          mod_v = $signed(u);
        end
        8, 9, 10: begin
          mod_v = 2 * $urandom_range(1, 127) + 1;
          if ($urandom_range(0, 1) == 0) res_v = $signed($urandom_range(0, 600)) - 300;
        end
        default: begin
          mod_v = {1'b0, u[30:1], 1'b1};
          if (mod_v == 1) mod_v = 32'sd3;
        end
      endcase
      send_beat(res_v, mod_v, 1'b0, '{SYM_ZERO, ST_OK});
      if (k == RANDOM_ITEMS / 2) drain_results();
      else pace_sender();
    end

    drain_results();
    repeat (2 * W + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/jsu_pkg.sv
src/jsu_datapath.sv
src/jsu_ctrl.sv
src/jacobi_symbol_unit.sv
verif/jacobi_symbol_unit_tb.sv
